FILE: rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache table.
// Used by lfu_mem, lfu_scan and lfu_cache_table; depends on nothing else.
package lfu_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 32;
  localparam int STAMP_W = 48;
  localparam int CFG_W   = 5;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [VALUE_W-1:0] MISS_VALUE = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
  localparam logic [CFG_W-1:0]   CFG_RESET  = CFG_W'(16);

  // One stored entry, kept as a single word of the entry memory.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } lfu_entry_t;

  // What a scan over the valid entries found.
  typedef struct packed {
    logic               match_found;
    logic [VALUE_W-1:0] match_value;
    logic [COUNT_W-1:0] match_count;
    logic               victim_found;
    logic [KEY_W-1:0]   victim_key;
  } lfu_scan_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } lfu_state_t;

endpackage

FILE: rtl/lfu_cache_table.sv
// Top level of the LFU cache table: control sequencer, write-back and result register.
// Depends on lfu_pkg, lfu_mem and lfu_scan.
//
//   Chan  Handshake             Payload                                         Accepted on
//   in    in_valid, in_ready    operation, key, value                           valid&ready
//   out   out_valid, out_ready  hit, read_value, written, evicted, evicted_key  valid&ready
//   cfg   cfg_write_en          cfg_write_data                                  write enable
//
// A word's result is registered after its entries are scanned: the single read
// port of the entry memory is scanned one slot per cycle, then the last compare
// finishes and the entry is written back while the result register loads. The
// block is then ready again for a new word.
// Reset is synchronous; it empties the table and restores capacity_in_use to 16.
// No clearing pass is needed, since the valid slots always form a prefix.
// A result waits in the output register; a new word is accepted meanwhile, and
// only the write-back of that new word stalls until the result is taken.
module lfu_cache_table #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [lfu_pkg::CFG_W-1:0]         cfg_write_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              operation,
  input  logic signed [lfu_pkg::KEY_W-1:0]  key,
  input  logic signed [lfu_pkg::VALUE_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic signed [lfu_pkg::VALUE_W-1:0] read_value,
  output logic                              written,
  output logic                              evicted,
  output logic signed [lfu_pkg::KEY_W-1:0]  evicted_key
);

  // Address width for the entry memory and a count width that can hold
  // CAPACITY itself. Compares against the 5-bit register use the wider of both.
  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (OCC_W > lfu_pkg::CFG_W) ? OCC_W : lfu_pkg::CFG_W;
  localparam logic [CMP_W-1:0] CAP_LIMIT = CMP_W'(CAPACITY);

  // Control state.
  lfu_pkg::lfu_state_t          state;
  lfu_pkg::lfu_state_t          state_next;
  logic [lfu_pkg::CFG_W-1:0]    capacity_in_use;
  logic [OCC_W-1:0]             occupancy;
  logic [OCC_W-1:0]             occupancy_next;
  logic [lfu_pkg::STAMP_W-1:0]  stamp_counter;
  logic [OCC_W-1:0]             scan_idx;
  logic                         rd_valid;
  logic [AW-1:0]                rd_slot;

  // The word being worked on.
  logic                         op_q;
  logic [lfu_pkg::KEY_W-1:0]    key_q;
  logic [lfu_pkg::VALUE_W-1:0]  value_q;

  // Memory and scan connections.
  logic                         rd_en;
  lfu_pkg::lfu_entry_t          rd_data;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  lfu_pkg::lfu_entry_t          wr_data;
  lfu_pkg::lfu_scan_t           scan;
  logic [AW-1:0]                match_slot;
  logic [AW-1:0]                victim_slot;

  // Decision signals for the write-back cycle.
  logic                         in_fire;
  logic                         commit;
  logic [CMP_W-1:0]             cap_eff;
  logic                         put_ok;
  logic                         put_miss;
  logic                         do_evict;
  logic                         get_hit;

  assign in_ready = (state == lfu_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign rd_en    = (state == lfu_pkg::ST_SCAN) && (scan_idx < occupancy);

  // Register values above CAPACITY act as CAPACITY.
  assign cap_eff  = (CMP_W'(capacity_in_use) > CAP_LIMIT) ? CAP_LIMIT
                                                          : CMP_W'(capacity_in_use);
  assign get_hit  = (op_q == lfu_pkg::OP_GET) && scan.match_found;
  assign put_ok   = (op_q == lfu_pkg::OP_PUT) && (cap_eff != '0);
  assign put_miss = put_ok && !scan.match_found;
  // Full (or over-full after a lowered capacity): replace one victim in place,
  // so occupancy stays and the valid slots remain a prefix.
  assign do_evict = put_miss && (CMP_W'(occupancy) >= cap_eff);

  // Sequencer: idle, scan the valid prefix, then write back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    commit         = 1'b0;
    occupancy_next = occupancy;
    unique case (state)
      lfu_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        // Once no read is issued, the last entry is being compared this cycle.
        if (!rd_en) begin
          state_next = lfu_pkg::ST_WRITE;
        end
      end
      lfu_pkg::ST_WRITE: begin
        if (!out_valid || out_ready) begin
          commit     = 1'b1;
          state_next = lfu_pkg::ST_IDLE;
          if (put_miss && !do_evict) begin
            occupancy_next = occupancy + OCC_W'(1);
          end
        end
      end
      default: begin
        state_next = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= lfu_pkg::CFG_RESET;
      occupancy       <= '0;
      stamp_counter   <= '0;
      scan_idx        <= '0;
      rd_valid        <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        capacity_in_use <= cfg_write_data;
      end
      occupancy <= occupancy_next;
      if (wr_en) begin
        stamp_counter <= stamp_counter + lfu_pkg::STAMP_W'(1);
      end
      if (in_fire) begin
        scan_idx <= '0;
      end else if (rd_en) begin
        scan_idx <= scan_idx + OCC_W'(1);
      end
      rd_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_slot <= scan_idx[AW-1:0];
    end
    if (in_fire) begin
      op_q    <= operation;
      key_q   <= key;
      value_q <= value;
    end
  end

  // Write-back: a hit refreshes its own slot, a put miss fills the next free
  // slot or overwrites the victim. Every write takes a fresh stamp.
  always_comb begin
    wr_en = commit && (get_hit || put_ok);
    if (scan.match_found) begin
      wr_addr = match_slot;
    end else if (do_evict) begin
      wr_addr = victim_slot;
    end else begin
      wr_addr = occupancy[AW-1:0];
    end
    wr_data.key   = key_q;
    wr_data.value = (op_q == lfu_pkg::OP_PUT) ? value_q : scan.match_value;
    if (!scan.match_found) begin
      wr_data.count = lfu_pkg::COUNT_ONE;
    end else if (scan.match_count == lfu_pkg::COUNT_MAX) begin
      wr_data.count = scan.match_count;
    end else begin
      wr_data.count = scan.match_count + lfu_pkg::COUNT_ONE;
    end
    wr_data.stamp = stamp_counter;
  end

  // Result register, parting the output side from the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit         <= scan.match_found;
      read_value  <= get_hit ? scan.match_value : lfu_pkg::MISS_VALUE;
      written     <= put_ok;
      evicted     <= do_evict;
      evicted_key <= do_evict ? scan.victim_key : '0;
    end
  end

  lfu_mem #(
    .Depth (CAPACITY),
    .AddrW (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lfu_scan #(
    .AddrW (AW)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (in_fire),
    .key         (key_q),
    .rd_valid    (rd_valid),
    .rd_slot     (rd_slot),
    .rd_data     (rd_data),
    .result      (scan),
    .match_slot  (match_slot),
    .victim_slot (victim_slot)
  );

  // An eviction reuses the victim's slot, so the fill count must not move.
  a_evict_keeps_occupancy: assert property (@(posedge clk) disable iff (rst)
    (commit && do_evict) |=> $stable(occupancy))
    else $error("occupancy changed on an eviction");

  // An insert without eviction grows the filled prefix by exactly one.
  a_insert_grows_occupancy: assert property (@(posedge clk) disable iff (rst)
    (commit && put_miss && !do_evict) |=> (occupancy == $past(occupancy) + OCC_W'(1)))
    else $error("occupancy did not grow on an insert");

  // A result appears only out of the write-back cycle.
  a_result_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == lfu_pkg::ST_WRITE))
    else $error("result shown outside write-back");

  // An eviction is only ever part of a stored put that missed.
  a_evict_is_put_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted) |-> (written && !hit))
    else $error("eviction reported on a hit or unstored word");

endmodule

FILE: rtl/lfu_mem.sv
// Entry memory: one synchronous read port with registered data, one write port.
// Depends on lfu_pkg for the entry word type.
module lfu_mem #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AddrW-1:0]    rd_addr,
  output lfu_pkg::lfu_entry_t rd_data,
  input  logic                wr_en,
  input  logic [AddrW-1:0]    wr_addr,
  input  lfu_pkg::lfu_entry_t wr_data
);

  lfu_pkg::lfu_entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lfu_scan.sv
// Scan unit: looks at one entry per cycle, keeps the key match and the
// least-used, oldest victim seen so far. Depends on lfu_pkg.
module lfu_scan #(
  parameter int AddrW = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lfu_pkg::KEY_W-1:0]   key,
  input  logic                        rd_valid,
  input  logic [AddrW-1:0]            rd_slot,
  input  lfu_pkg::lfu_entry_t         rd_data,
  output lfu_pkg::lfu_scan_t          result,
  output logic [AddrW-1:0]            match_slot,
  output logic [AddrW-1:0]            victim_slot
);

  logic [lfu_pkg::COUNT_W-1:0] victim_count;
  logic [lfu_pkg::STAMP_W-1:0] victim_stamp;
  logic                        is_match;
  logic                        is_better;

  assign is_match  = rd_valid && !result.match_found && (rd_data.key == key);
  // Strictly better only, so on a full tie the lower slot seen first stays.
  assign is_better = rd_valid && (!result.victim_found ||
                     (rd_data.count < victim_count) ||
                     ((rd_data.count == victim_count) && (rd_data.stamp < victim_stamp)));

  always_ff @(posedge clk) begin
    if (rst || start) begin
      result.match_found  <= 1'b0;
      result.victim_found <= 1'b0;
    end else begin
      if (is_match) begin
        result.match_found <= 1'b1;
      end
      if (is_better) begin
        result.victim_found <= 1'b1;
      end
    end
    if (is_match) begin
      result.match_value <= rd_data.value;
      result.match_count <= rd_data.count;
      match_slot         <= rd_slot;
    end
    if (is_better) begin
      result.victim_key <= rd_data.key;
      victim_count      <= rd_data.count;
      victim_stamp      <= rd_data.stamp;
      victim_slot       <= rd_slot;
    end
  end

endmodule
